[rtl/best_fit_free_list_allocator_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit allocator
// Implication checks, same-cycle and next-cycle, with reset disable.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define BEST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// ante holds, so cons holds in the same cycle
`define BFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion %m failed");

// ante holds, so cons holds in the next cycle
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion %m failed");

`endif

[rtl/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// bfa_pkg
// Sizes, header entry layout, controller states and helpers of the allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int POOL_BYTES   = 4096;
    localparam int HEADER_BYTES = 16;

    localparam int ADDR_W  = $clog2(POOL_BYTES);
    localparam int LINK_W  = ADDR_W + 1;
    localparam int SIZE_W  = ADDR_W + 1;
    localparam int SUM_W   = SIZE_W + 1;
    localparam int ENTRY_W = SIZE_W + LINK_W;

    localparam logic [LINK_W-1:0] NIL_LINK  = '1;
    localparam logic [SIZE_W-1:0] HDR_SIZE  = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] SPLIT_MIN = SIZE_W'(2 * HEADER_BYTES);
    localparam logic [SIZE_W-1:0] MIN_POOL  = SIZE_W'(HEADER_BYTES + 1);
    localparam logic [SIZE_W-1:0] MAX_POOL  = SIZE_W'(POOL_BYTES);
    localparam logic [SUM_W-1:0]  HDR_SUM   = SUM_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] HDR_ADDR  = ADDR_W'(HEADER_BYTES);

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_WALK,
        ST_A_FIX,
        ST_A_SHRINK,
        ST_A_LINK,
        ST_R_WALK,
        ST_R_CHK,
        ST_R_GETH,
        ST_R_GETC,
        ST_R_WH,
        ST_R_WP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [LINK_W-1:0] next;
    } t_entry;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] payload_offset;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [LINK_W-1:0] norm_link(input logic [LINK_W-1:0] x,
                                                    input logic [SIZE_W-1:0] limit);
        return (x < limit) ? x : NIL_LINK;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_pool(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < MIN_POOL) begin
            r = MIN_POOL;
        end else if (v > MAX_POOL) begin
            r = MAX_POOL;
        end
        return r;
    endfunction

endpackage

[rtl/bfa_req_if.sv]
// ----------------------------------------------------------------------------
// bfa_req_if
// Request channel: allocate or release word with valid/ready.
// ----------------------------------------------------------------------------
interface bfa_req_if import bfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] release_offset;

    modport source (output valid, operation, request_size, release_offset, input ready);
    modport sink   (input valid, operation, request_size, release_offset, output ready);
endinterface

[rtl/bfa_rsp_if.sv]
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Response channel: status and payload offset word with valid/ready.
// ----------------------------------------------------------------------------
interface bfa_rsp_if import bfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [ADDR_W-1:0] payload_offset;

    modport source (output valid, ok, payload_offset, input ready);
    modport sink   (input valid, ok, payload_offset, output ready);
endinterface

[rtl/bfa_cfg_if.sv]
// ----------------------------------------------------------------------------
// bfa_cfg_if
// Configuration write channel: pool size word with valid/ready.
// ----------------------------------------------------------------------------
interface bfa_cfg_if import bfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] pool_size;

    modport source (output valid, pool_size, input ready);
    modport sink   (input valid, pool_size, output ready);
endinterface

[rtl/bfa_ram.sv]
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bfa_out.sv]
// ----------------------------------------------------------------------------
// bfa_out
// Output register between the controller and the response channel.
// ----------------------------------------------------------------------------
module bfa_out import bfa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_result   i_data,
    bfa_rsp_if.source o_rsp
);

    logic    r_valid;
    logic    n_valid;
    t_result r_data;

    assign o_ready = !r_valid || o_rsp.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload: load only when the register frees up
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.ok             = r_data.ok;
    assign o_rsp.payload_offset = r_data.payload_offset;

endmodule

[rtl/bfa_ctrl.sv]
// ----------------------------------------------------------------------------
// bfa_ctrl
// List walker: best-fit search, split, insert and merge over the header RAM.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bfa_req_if.sink i_req,
    bfa_cfg_if.sink i_cfg,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res,
    output t_mem_req o_mem,
    input  t_entry  i_rdata
);

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_pool_limit, n_pool_limit;
    logic [LINK_W-1:0] r_head, n_head;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [SIZE_W-1:0] r_prev_size, n_prev_size;
    logic [SIZE_W-1:0] r_req, n_req;
    logic [ADDR_W-1:0] r_h, n_h;
    logic              r_found, n_found;
    logic [LINK_W-1:0] r_best, n_best;
    logic [LINK_W-1:0] r_best_prev, n_best_prev;
    logic [SIZE_W-1:0] r_best_prev_size, n_best_prev_size;
    logic [SIZE_W-1:0] r_best_size, n_best_size;
    logic [LINK_W-1:0] r_best_raw, n_best_raw;
    logic [LINK_W-1:0] r_after, n_after;
    logic [LINK_W-1:0] r_link_to, n_link_to;
    logic [SIZE_W-1:0] r_size_h, n_size_h;
    logic              r_mp, n_mp;
    logic [LINK_W-1:0] r_t, n_t;
    logic [SIZE_W-1:0] r_tsize, n_tsize;
    logic [SIZE_W-1:0] r_fsize, n_fsize;
    logic [LINK_W-1:0] r_fnext, n_fnext;
    logic              r_res_ok, n_res_ok;
    logic [ADDR_W-1:0] r_res_off, n_res_off;

    logic              w_req_acc;
    logic              w_is_rel;
    logic [LINK_W-1:0] w_head_n;
    logic [ADDR_W-1:0] w_rel_h;
    logic              w_rel_skip;
    logic              w_rel_short;
    logic [LINK_W-1:0] w_rd_nx;
    logic              w_fit;
    logic              w_rwalk_end;
    logic [SUM_W-1:0]  w_split_at;
    logic              w_do_split;
    logic              w_mp;
    logic              w_mc;
    logic              w_cur_is_h;

    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_is_rel    = (i_req.operation == OP_RELEASE);
    assign w_head_n    = norm_link(r_head, r_pool_limit);
    assign w_rel_h     = i_req.release_offset - HDR_ADDR;
    assign w_rel_skip  = (i_req.release_offset < HDR_ADDR) ||
                         ({1'b0, w_rel_h} >= r_pool_limit);
    assign w_rel_short = (w_head_n == NIL_LINK) || (w_head_n >= {1'b0, w_rel_h});
    assign w_rd_nx     = norm_link(i_rdata.next, r_pool_limit);
    assign w_fit       = (i_rdata.size >= r_req) && (!r_found || (i_rdata.size < r_best_size));
    assign w_rwalk_end = (w_rd_nx == NIL_LINK) || (w_rd_nx >= {1'b0, r_h});
    assign w_split_at  = SUM_W'(r_best) + HDR_SUM + SUM_W'(r_req);
    assign w_do_split  = ((r_best_size - r_req) >= SPLIT_MIN) &&
                         (w_split_at < SUM_W'(r_pool_limit)) &&
                         ((r_after == NIL_LINK) || (w_split_at < SUM_W'(r_after)));
    // block just below touches the released one
    assign w_mp        = (r_prev != NIL_LINK) &&
                         ((SUM_W'(r_prev) + HDR_SUM + SUM_W'(r_prev_size)) == SUM_W'(r_h));
    // merged block touches the free block just above
    assign w_mc        = (r_cur != NIL_LINK) &&
                         ((SUM_W'(r_t) + HDR_SUM + SUM_W'(r_tsize)) == SUM_W'(r_cur));
    assign w_cur_is_h  = (r_cur == {1'b0, r_h});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_req_acc) begin
                    if (!w_is_rel) begin
                        if ((i_req.request_size == '0) || (w_head_n == NIL_LINK)) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_A_WALK;
                        end
                    end else if (w_rel_skip) begin
                        n_state = ST_DONE;
                    end else if (w_rel_short) begin
                        n_state = ST_R_CHK;
                    end else begin
                        n_state = ST_R_WALK;
                    end
                end
            end
            ST_A_WALK: begin
                if (w_rd_nx == NIL_LINK) begin
                    n_state = ST_A_FIX;
                end
            end
            ST_A_FIX: begin
                if (!r_found) begin
                    n_state = ST_DONE;
                end else if (w_do_split) begin
                    n_state = ST_A_SHRINK;
                end else begin
                    n_state = ST_A_LINK;
                end
            end
            ST_A_SHRINK: begin
                n_state = ST_A_LINK;
            end
            ST_A_LINK: begin
                n_state = ST_DONE;
            end
            ST_R_WALK: begin
                if (w_rwalk_end) begin
                    n_state = ST_R_CHK;
                end
            end
            ST_R_CHK: begin
                n_state = w_cur_is_h ? ST_DONE : ST_R_GETH;
            end
            ST_R_GETH: begin
                n_state = ST_R_GETC;
            end
            ST_R_GETC: begin
                n_state = ST_R_WH;
            end
            ST_R_WH: begin
                n_state = ST_R_WP;
            end
            ST_R_WP: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
        // a pool size write rebuilds the list from scratch
        if (i_cfg.valid) begin
            n_state = ST_INIT;
        end
    end

    // outputs: RAM accesses and handshakes
    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = '{ok: r_res_ok, payload_offset: r_res_off};

    always_comb begin
        o_mem = '0;
        case (r_state)
            ST_INIT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = '0;
                o_mem.wdata = '{size: r_pool_limit - HDR_SIZE, next: NIL_LINK};
            end
            ST_IDLE: begin
                o_mem.raddr = w_head_n[ADDR_W-1:0];
                if (w_req_acc && (w_head_n != NIL_LINK)) begin
                    if (!w_is_rel) begin
                        o_mem.re = (i_req.request_size != '0);
                    end else begin
                        o_mem.re = !w_rel_skip && !w_rel_short;
                    end
                end
            end
            ST_A_WALK: begin
                o_mem.re    = (w_rd_nx != NIL_LINK);
                o_mem.raddr = w_rd_nx[ADDR_W-1:0];
            end
            ST_A_FIX: begin
                o_mem.we    = r_found && w_do_split;
                o_mem.waddr = w_split_at[ADDR_W-1:0];
                o_mem.wdata = '{size: r_best_size - r_req - HDR_SIZE, next: r_after};
            end
            ST_A_SHRINK: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_best[ADDR_W-1:0];
                o_mem.wdata = '{size: r_req, next: r_best_raw};
            end
            ST_A_LINK: begin
                o_mem.we    = (r_best_prev != NIL_LINK);
                o_mem.waddr = r_best_prev[ADDR_W-1:0];
                o_mem.wdata = '{size: r_best_prev_size, next: r_link_to};
            end
            ST_R_WALK: begin
                o_mem.re    = !w_rwalk_end;
                o_mem.raddr = w_rd_nx[ADDR_W-1:0];
            end
            ST_R_CHK: begin
                o_mem.re    = !w_cur_is_h;
                o_mem.raddr = r_h;
            end
            ST_R_GETH: begin
                o_mem.re    = (r_cur != NIL_LINK);
                o_mem.raddr = r_cur[ADDR_W-1:0];
            end
            ST_R_WH: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_h;
                o_mem.wdata = r_mp ? t_entry'{size: r_size_h, next: r_cur}
                                   : t_entry'{size: r_fsize, next: r_fnext};
            end
            ST_R_WP: begin
                o_mem.we    = (r_prev != NIL_LINK);
                o_mem.waddr = r_prev[ADDR_W-1:0];
                o_mem.wdata = r_mp ? t_entry'{size: r_fsize, next: r_fnext}
                                   : t_entry'{size: r_prev_size, next: {1'b0, r_h}};
            end
            default: begin
                o_mem = '0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_pool_limit     = r_pool_limit;
        n_head           = r_head;
        n_cur            = r_cur;
        n_prev           = r_prev;
        n_prev_size      = r_prev_size;
        n_req            = r_req;
        n_h              = r_h;
        n_found          = r_found;
        n_best           = r_best;
        n_best_prev      = r_best_prev;
        n_best_prev_size = r_best_prev_size;
        n_best_size      = r_best_size;
        n_best_raw       = r_best_raw;
        n_after          = r_after;
        n_link_to        = r_link_to;
        n_size_h         = r_size_h;
        n_mp             = r_mp;
        n_t              = r_t;
        n_tsize          = r_tsize;
        n_fsize          = r_fsize;
        n_fnext          = r_fnext;
        n_res_ok         = r_res_ok;
        n_res_off        = r_res_off;
        case (r_state)
            ST_IDLE: begin
                if (w_req_acc) begin
                    n_req     = i_req.request_size;
                    n_h       = w_rel_h;
                    n_cur     = w_head_n;
                    n_prev    = NIL_LINK;
                    n_found   = 1'b0;
                    n_res_ok  = w_is_rel;
                    n_res_off = '0;
                end
            end
            ST_A_WALK: begin
                if (w_fit) begin
                    n_found          = 1'b1;
                    n_best           = r_cur;
                    n_best_prev      = r_prev;
                    n_best_prev_size = r_prev_size;
                    n_best_size      = i_rdata.size;
                    n_best_raw       = i_rdata.next;
                    n_after          = w_rd_nx;
                end
                n_prev      = r_cur;
                n_prev_size = i_rdata.size;
                n_cur       = w_rd_nx;
            end
            ST_A_FIX: begin
                n_link_to = w_do_split ? w_split_at[LINK_W-1:0] : r_after;
            end
            ST_A_LINK: begin
                if (r_best_prev == NIL_LINK) begin
                    n_head = r_link_to;
                end
                n_res_ok  = 1'b1;
                n_res_off = r_best[ADDR_W-1:0] + HDR_ADDR;
            end
            ST_R_WALK: begin
                n_prev      = r_cur;
                n_prev_size = i_rdata.size;
                n_cur       = w_rd_nx;
            end
            ST_R_GETH: begin
                n_size_h = i_rdata.size;
                n_mp     = w_mp;
                n_t      = w_mp ? r_prev : {1'b0, r_h};
                n_tsize  = w_mp ? (r_prev_size + HDR_SIZE + i_rdata.size) : i_rdata.size;
            end
            ST_R_GETC: begin
                n_fsize = w_mc ? (r_tsize + HDR_SIZE + i_rdata.size) : r_tsize;
                n_fnext = w_mc ? i_rdata.next : r_cur;
            end
            ST_R_WP: begin
                if (r_prev == NIL_LINK) begin
                    n_head = {1'b0, r_h};
                end
            end
            default: begin
            end
        endcase
        if (i_cfg.valid) begin
            n_pool_limit = clamp_pool(i_cfg.pool_size);
            n_head       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_pool_limit <= MAX_POOL;
            r_head       <= '0;
        end else begin
            r_state      <= n_state;
            r_pool_limit <= n_pool_limit;
            r_head       <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur            <= n_cur;
        r_prev           <= n_prev;
        r_prev_size      <= n_prev_size;
        r_req            <= n_req;
        r_h              <= n_h;
        r_found          <= n_found;
        r_best           <= n_best;
        r_best_prev      <= n_best_prev;
        r_best_prev_size <= n_best_prev_size;
        r_best_size      <= n_best_size;
        r_best_raw       <= n_best_raw;
        r_after          <= n_after;
        r_link_to        <= n_link_to;
        r_size_h         <= n_size_h;
        r_mp             <= n_mp;
        r_t              <= n_t;
        r_tsize          <= n_tsize;
        r_fsize          <= n_fsize;
        r_fnext          <= n_fnext;
        r_res_ok         <= n_res_ok;
        r_res_off        <= n_res_off;
    end

endmodule

[rtl/best_fit_free_list_allocator_top.sv]
// Best-fit allocator over a 4096-byte pool. Block headers (payload size and
// next free offset) live in one 4096 x 26 RAM with a registered read; the
// free list is kept in address order and walked one entry per cycle. An
// allocate walks the whole free list and a release only the free blocks
// below the released one. After reset and after every pool size write the
// controller rebuilds the list head entry before it takes a request. The
// response goes through an output register, so a new request word is taken
// while a response still waits.
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator_top
// Best-fit free-list allocator with split and coalescing on release.
// ----------------------------------------------------------------------------
`include "best_fit_free_list_allocator_top_assert.svh"

module best_fit_free_list_allocator_top import bfa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfa_req_if.sink   i_req,
    bfa_rsp_if.source o_rsp,
    bfa_cfg_if.sink   i_cfg
);

    t_mem_req w_mem;
    t_entry   w_rdata;
    t_result  w_res;
    logic     w_res_valid;
    logic     w_res_ready;

    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg       (i_cfg),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem       (w_mem),
        .i_rdata     (w_rdata)
    );

    bfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_BYTES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    bfa_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_data  (w_res),
        .o_rsp   (o_rsp)
    );

    // read-modify-write never reads and writes the same header in one cycle
    `BFA_ASSERT_IMPL(a_no_rw_clash, i_clk, i_rst_n, w_mem.we && w_mem.re, w_mem.waddr != w_mem.raddr)
    // a pool size write rebuilds the head entry on the next cycle
    `BFA_ASSERT_NEXT(a_cfg_rebuild, i_clk, i_rst_n, i_cfg.valid && i_cfg.ready, w_mem.we && (w_mem.waddr == '0))
    // no new request word while the controller still holds a response
    `BFA_ASSERT_IMPL(a_accept_drained, i_clk, i_rst_n, i_req.valid && i_req.ready, !w_res_valid)
    // a handed-over response shows on the port next cycle
    `BFA_ASSERT_NEXT(a_res_shown, i_clk, i_rst_n, w_res_valid && w_res_ready, o_rsp.valid)

endmodule

[dv/tb_best_fit_free_list_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_free_list_allocator_top
// Drives allocate and release words into the best-fit allocator, keeps a
// shadow copy of the block headers and the free list to predict every
// response, and checks each response word in order. Pool size is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_best_fit_free_list_allocator_top import bfa_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned NO_LINK     = NIL_LINK;
    localparam int unsigned OFFSET_MAX  = (1 << ADDR_W) - 1;

    // Shadow of the header store and free list, plus the queue of awaited responses.
    class pool_scoreboard;
        logic [SIZE_W-1:0] blk_size [POOL_BYTES];
        logic [LINK_W-1:0] blk_next [POOL_BYTES];
        bit                hdr_written [POOL_BYTES];
        int unsigned       seen_hdrs[$];
        int unsigned       live_offsets[$];
        int unsigned       limit;
        int unsigned       head;
        int unsigned       last_grant;
        int                mismatches;
        t_result           awaited[$];

        function new();
            for (int i = 0; i < POOL_BYTES; i++) begin
                blk_size[i]    = '0;
                blk_next[i]    = '0;
                hdr_written[i] = 1'b0;
            end
            mismatches = 0;
            last_grant = 0;
            set_pool(POOL_BYTES);
        endfunction

        function void mark(int unsigned h);
            if (!hdr_written[h]) begin
                hdr_written[h] = 1'b1;
                seen_hdrs.push_back(h);
            end
        endfunction

        function void set_pool(int unsigned value);
            int unsigned v;
            v = value & ((1 << SIZE_W) - 1);
            if (v < HEADER_BYTES + 1) v = HEADER_BYTES + 1;
            if (v > POOL_BYTES) v = POOL_BYTES;
            limit       = v;
            head        = 0;
            blk_size[0] = SIZE_W'(limit - HEADER_BYTES);
            blk_next[0] = NIL_LINK;
            mark(0);
            live_offsets.delete();
        endfunction

        function int unsigned follow(int unsigned x);
            return (x < limit) ? x : NO_LINK;
        endfunction

        function void relink(int unsigned from, int unsigned to);
            if (from == NO_LINK) head = to;
            else blk_next[from] = LINK_W'(to);
        endfunction

        // Best fit over the whole list, lower address on a tie; split when worthwhile.
        function bit carve(int unsigned req, output int unsigned grant);
            int unsigned cur, prev, best, best_prev, best_sz, sz, after, split_at;
            bit          found;
            cur       = follow(head);
            prev      = NO_LINK;
            best      = NO_LINK;
            best_prev = NO_LINK;
            best_sz   = 0;
            found     = 1'b0;
            grant     = 0;
            if (req == 0) return 1'b0;
            for (int unsigned steps = 0; steps < limit && cur != NO_LINK; steps++) begin
                sz = blk_size[cur];
                if (sz >= req && (!found || sz < best_sz)) begin
                    found     = 1'b1;
                    best      = cur;
                    best_prev = prev;
                    best_sz   = sz;
                end
                prev = cur;
                cur  = follow(blk_next[cur]);
            end
            if (!found) return 1'b0;
            after    = follow(blk_next[best]);
            split_at = best + HEADER_BYTES + req;
            if (best_sz - req >= 2 * HEADER_BYTES && split_at < limit &&
                (after == NO_LINK || split_at < after)) begin
                blk_size[split_at] = SIZE_W'(best_sz - req - HEADER_BYTES);
                blk_next[split_at] = LINK_W'(after);
                mark(split_at);
                relink(best_prev, split_at);
                blk_size[best] = SIZE_W'(req);
            end else begin
                relink(best_prev, after);
            end
            grant = best + HEADER_BYTES;
            return 1'b1;
        endfunction

        // Insert in address order and merge with touching free neighbours.
        function void give_back(int unsigned off);
            int unsigned h, cur, prev;
            prev = NO_LINK;
            if (off < HEADER_BYTES) return;
            h = off - HEADER_BYTES;
            if (h >= limit) return;
            cur = follow(head);
            for (int unsigned steps = 0; steps < limit && cur != NO_LINK && cur < h; steps++) begin
                prev = cur;
                cur  = follow(blk_next[cur]);
            end
            if (cur == h) return;
            blk_next[h] = LINK_W'(cur);
            if (prev != NO_LINK) begin
                blk_next[prev] = LINK_W'(h);
                if (prev + HEADER_BYTES + blk_size[prev] == h) begin
                    blk_size[prev] = SIZE_W'(blk_size[prev] + HEADER_BYTES + blk_size[h]);
                    blk_next[prev] = blk_next[h];
                    h = prev;
                end
            end else begin
                head = h;
            end
            if (cur != NO_LINK && h + HEADER_BYTES + blk_size[h] == cur) begin
                blk_size[h] = SIZE_W'(blk_size[h] + HEADER_BYTES + blk_size[cur]);
                blk_next[h] = blk_next[cur];
            end
        endfunction

        function void note_request(t_op op, int unsigned req, int unsigned off);
            t_result     r;
            int unsigned g;
            int          idx[$];
            r = '0;
            if (op == OP_ALLOC) begin
                if (carve(req, g)) begin
                    r.ok             = 1'b1;
                    r.payload_offset = ADDR_W'(g);
                    last_grant       = g & OFFSET_MAX;
                    live_offsets.push_back(last_grant);
                end
            end else begin
                give_back(off);
                r.ok = 1'b1;
                idx  = live_offsets.find_first_index(x) with (x == off);
                if (idx.size() != 0) live_offsets.delete(idx[0]);
            end
            awaited.push_back(r);
        endfunction

        function void check_response(logic ok, logic [ADDR_W-1:0] payload_offset);
            t_result e;
            if (awaited.size() == 0) begin
                $error("response word with nothing outstanding: ok %0d payload_offset %0d",
                       ok, payload_offset);
                mismatches++;
                return;
            end
            e = awaited.pop_front();
            if (ok !== e.ok) begin
                $error("ok: expected %0d, got %0d", e.ok, ok);
                mismatches++;
            end
            if (payload_offset !== e.payload_offset) begin
                $error("payload_offset: expected %0d, got %0d", e.payload_offset, payload_offset);
                mismatches++;
            end
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    bit             calm;
    int unsigned    cycles;
    pool_scoreboard sb;

    bfa_req_if req_if ();
    bfa_rsp_if rsp_if ();
    bfa_cfg_if cfg_if ();

    best_fit_free_list_allocator_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit pause_now();
        return !calm && ($urandom_range(99) < 10);
    endfunction

    always @(negedge i_clk) begin
        rsp_if.ready = !pause_now();
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_response(rsp_if.ok, rsp_if.payload_offset);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic issue(t_op op, int unsigned req, int unsigned off);
        while (pause_now()) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid          = 1'b1;
        req_if.operation      = op;
        req_if.request_size   = SIZE_W'(req);
        req_if.release_offset = ADDR_W'(off);
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(op, req, off);
        @(negedge i_clk);
    endtask

    task automatic write_pool(int unsigned value);
        req_if.valid = 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        cfg_if.valid     = 1'b1;
        cfg_if.pool_size = SIZE_W'(value);
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.set_pool(value);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic int unsigned pick_size();
        int unsigned s, room;
        s    = $urandom_range(99);
        room = sb.limit - HEADER_BYTES;
        if (s < 3) return 0;
        if (s < 6) return $urandom_range(POOL_BYTES, (1 << SIZE_W) - 1);
        if (s < 10) return (room > 40) ? room - $urandom_range(0, 40) : $urandom_range(1, room + 2);
        if (s < 60) return $urandom_range(1, 32);
        if (s < 85) return $urandom_range(33, 256);
        return $urandom_range(257, 1024);
    endfunction

    // One random word; counted is low for the extra releases at bad or earlier-seen offsets.
    task automatic random_word(output bit counted);
        int unsigned r, off, h;
        r       = $urandom_range(99);
        counted = 1'b1;
        if (sb.live_offsets.size() == 0 || r < 50) begin
            issue(OP_ALLOC, pick_size(), 0);
        end else if (r < 93) begin
            off = sb.live_offsets[$urandom_range(sb.live_offsets.size() - 1)];
            issue(OP_RELEASE, 0, off);
        end else begin
            counted = 1'b0;
            off     = $urandom_range(0, HEADER_BYTES - 1);
            if (r >= 95 && r < 97 && sb.limit + HEADER_BYTES <= OFFSET_MAX) begin
                off = $urandom_range(sb.limit + HEADER_BYTES, OFFSET_MAX);
            end else if (r >= 97 && r < 99 && sb.head < sb.limit &&
                         sb.head + HEADER_BYTES <= OFFSET_MAX) begin
                off = sb.head + HEADER_BYTES;
            end else if (r == 99) begin
                // any header written so far, possibly one left behind by an earlier merge or pool rewrite
                h = sb.seen_hdrs[$urandom_range(sb.seen_hdrs.size() - 1)];
                if (h + HEADER_BYTES <= OFFSET_MAX) off = h + HEADER_BYTES;
            end
            issue(OP_RELEASE, $urandom_range(0, (1 << SIZE_W) - 1), off);
        end
    endtask

    initial begin
        int unsigned a, b, c, d, pool, phase_len, done;
        bit          counted;

        sb                    = new();
        cycles                = 0;
        calm                  = 1'b0;
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.operation      = OP_ALLOC;
        req_if.request_size   = '0;
        req_if.release_offset = '0;
        rsp_if.ready          = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.pool_size      = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: failing sizes, whole-pool grab, ignored releases, split and merge.
        issue(OP_ALLOC, 0, 0);
        issue(OP_ALLOC, (1 << SIZE_W) - 1, 0);
        issue(OP_ALLOC, POOL_BYTES, 0);
        issue(OP_ALLOC, POOL_BYTES - HEADER_BYTES, 0);
        issue(OP_RELEASE, 0, sb.last_grant);
        issue(OP_RELEASE, 0, 5);
        issue(OP_RELEASE, 0, HEADER_BYTES);
        issue(OP_ALLOC, 40, 0);
        a = sb.last_grant;
        issue(OP_ALLOC, 40, 0);
        b = sb.last_grant;
        issue(OP_ALLOC, 40, 0);
        c = sb.last_grant;
        issue(OP_ALLOC, 40, 0);
        d = sb.last_grant;
        issue(OP_RELEASE, 0, a);
        issue(OP_RELEASE, 0, c);
        issue(OP_ALLOC, 40, 0);
        issue(OP_RELEASE, 0, sb.last_grant);
        issue(OP_RELEASE, 0, b);
        issue(OP_RELEASE, 0, d);
        issue(OP_ALLOC, POOL_BYTES - 3 * HEADER_BYTES, 0);
        issue(OP_RELEASE, 0, sb.last_grant);
        issue(OP_ALLOC, POOL_BYTES - 3 * HEADER_BYTES + 1, 0);
        issue(OP_RELEASE, 0, sb.last_grant);
        write_pool(HEADER_BYTES + 1);
        issue(OP_ALLOC, 1, 0);
        issue(OP_ALLOC, 1, 0);
        issue(OP_RELEASE, 0, OFFSET_MAX);
        issue(OP_RELEASE, 0, HEADER_BYTES);

        for (int p = 0; p < 14; p++) begin
            case (p)
                0:       pool = POOL_BYTES;
                1:       pool = HEADER_BYTES + 1;
                2:       pool = 0;
                3:       pool = (1 << SIZE_W) - 1;
                default: pool = ($urandom_range(3) == 0) ? $urandom_range(60, 600)
                                                         : $urandom_range(HEADER_BYTES + 1,
                                                                          POOL_BYTES);
            endcase
            write_pool(pool);
            calm      = (p == 6);
            phase_len = (p < 4) ? 60 : 155;
            done      = 0;
            while (done < phase_len) begin
                random_word(counted);
                if (counted) done++;
            end
        end
        calm = 1'b0;

        req_if.valid = 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
